/* design/spfl_pkg.sv */
// Shared types and constants for the spectral peak frequency lock unit.
`timescale 1ns / 1ps

package spfl_pkg;

   localparam int WIN_DEPTH  = 5;
   localparam int HOLD_DEPTH = WIN_DEPTH - 1;
   localparam int CNT_W      = $clog2(WIN_DEPTH + 1);
   localparam int AMP_W      = 24;
   localparam int FREQ_W     = 32;
   // 1% tolerance: snap when TOL_SCALE * |f - peak| < peak
   localparam int TOL_SCALE  = 100;
   localparam int PROD_W     = FREQ_W + 1 + $clog2(TOL_SCALE);

   // CSR map, byte address = 4 * index
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_LOCK_ENABLE = 1'b0;

   typedef struct packed {
      logic [AMP_W-1:0]         amp;
      logic signed [FREQ_W-1:0] freq;
      logic                     last;
   } bin_type;

   typedef bin_type [WIN_DEPTH-1:0] win_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      win_type          slot;
   } burst_type;

endpackage

/* design/spectral_peak_frequency_lock_unit.sv */
// Top level of the spectral peak frequency lock unit with its CSR port.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  bin amplitude, frequency, last flag
//   rsp      out        rsp_valid/rsp_stall  amplitude, locked frequency, frame end
//   csr      in/out     APB, pready high     lock_enable at byte address 0
//
// One bin is taken per cycle while req_stall is low; a bin leaves four positions
// after it arrives, from the queue register loaded when that later bin is taken.
// The last bin of a frame releases up to five words, drained one per cycle from
// the output queue while rsp_stall is low; req_stall stays high until the final
// one goes out. Reset empties the window and queue and sets lock_enable to 1.
// A stalled output keeps its word; input stalls once the queue cannot empty.
`timescale 1ns / 1ps

module spectral_peak_frequency_lock_unit
   import spfl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [AMP_W-1:0]         req_bin_amplitude,
   input  logic signed [FREQ_W-1:0] req_bin_frequency,
   input  logic                     req_last_bin,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [AMP_W-1:0]         rsp_out_amplitude,
   output logic signed [FREQ_W-1:0] rsp_out_frequency,
   output logic                     rsp_frame_end,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   logic      lock_enable_ff;
   logic      csr_write;
   logic      space;
   logic      accept;
   bin_type   bin_in;
   bin_type   out_word;
   burst_type burst;

   // config register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_LOCK_ENABLE)
                       ? {31'b0, lock_enable_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_enable_ff <= 1'b1;
      end else if (csr_write && csr_paddr[CSR_ADDR_W-1] == CSR_IDX_LOCK_ENABLE) begin
         lock_enable_ff <= csr_pwdata[0];
      end
   end

   // input word
   assign req_stall   = !space;
   assign accept      = req_valid && space;
   assign bin_in.amp  = req_bin_amplitude;
   assign bin_in.freq = req_bin_frequency;
   assign bin_in.last = req_last_bin;

   spfl_window u_window (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .bin_in      (bin_in),
      .lock_enable (lock_enable_ff),
      .burst       (burst)
   );

   spfl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .burst     (burst),
      .space     (space),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (out_word)
   );

   // output word
   assign rsp_out_amplitude = out_word.amp;
   assign rsp_out_frequency = out_word.freq;
   assign rsp_frame_end     = out_word.last;

endmodule

/* design/spfl_lock.sv */
// Peak detect and frequency snap over a full five-bin window.
`timescale 1ns / 1ps

module spfl_lock
   import spfl_pkg::*;
(
   input  logic    enable,
   input  win_type win_in,
   output win_type win_out
);

   localparam int CENTER = WIN_DEPTH / 2;

   logic                     is_peak;
   logic signed [FREQ_W-1:0] peak;
   logic                     peak_pos;

   // center must strictly beat every other bin
   always_comb begin
      is_peak = 1'b1;
      for (int k = 0; k < WIN_DEPTH; k++) begin
         if (k != CENTER && !(win_in[CENTER].amp > win_in[k].amp)) begin
            is_peak = 1'b0;
         end
      end
   end

   assign peak     = win_in[CENTER].freq;
   assign peak_pos = !peak[FREQ_W-1] && (peak != '0);

   // snap each bin within tolerance of the peak
   always_comb begin
      logic signed [FREQ_W:0] diff;
      logic [FREQ_W:0]        mag;
      logic [PROD_W-1:0]      mag_ext;
      logic [PROD_W-1:0]      prod;
      logic [PROD_W-1:0]      peak_ext;
      diff     = '0;
      mag      = '0;
      mag_ext  = '0;
      prod     = '0;
      peak_ext = {{(PROD_W-FREQ_W){1'b0}}, peak};
      win_out  = win_in;
      for (int k = 0; k < WIN_DEPTH; k++) begin
         diff    = {win_in[k].freq[FREQ_W-1], win_in[k].freq} - {peak[FREQ_W-1], peak};
         mag     = diff[FREQ_W] ? (~diff + 1'b1) : diff;
         mag_ext = {{(PROD_W-FREQ_W-1){1'b0}}, mag};
         // times 100 as 64 + 32 + 4
         prod    = (mag_ext << 6) + (mag_ext << 5) + (mag_ext << 2);
         if (enable && is_peak && peak_pos && (prod < peak_ext)) begin
            win_out[k].freq = peak;
         end
      end
   end

endmodule

/* design/spfl_window.sv */
// Sliding bin window: insert, lock, and select the words to emit.
`timescale 1ns / 1ps

module spfl_window
   import spfl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  bin_type   bin_in,
   input  logic      lock_enable,
   output burst_type burst
);

   bin_type [HOLD_DEPTH-1:0] hold_ff, hold_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   win_type                  win;
   win_type                  locked;
   logic                     full;

   assign full = (fill_ff == CNT_W'(HOLD_DEPTH));

   // place the new bin behind the held ones
   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         win[i] = bin_in;
      end
      for (int i = 0; i < HOLD_DEPTH; i++) begin
         if (CNT_W'(i) < fill_ff) begin
            win[i] = hold_ff[i];
         end
      end
   end

   spfl_lock u_lock (
      .enable  (full && (lock_enable == 1'b1)),
      .win_in  (win),
      .win_out (locked)
   );

   // pick output words and the next held window
   always_comb begin
      burst.slot  = locked;
      burst.count = '0;
      for (int i = 0; i < HOLD_DEPTH; i++) begin
         hold_in[i] = win[i];
      end
      fill_in = fill_ff + 1'b1;
      for (int k = 0; k < WIN_DEPTH; k++) begin
         burst.slot[k].last = (CNT_W'(k) == fill_ff);
      end
      if (bin_in.last) begin
         burst.count = fill_ff + 1'b1;
         fill_in     = '0;
      end else if (full) begin
         burst.count = CNT_W'(1);
         for (int i = 0; i < HOLD_DEPTH; i++) begin
            hold_in[i] = locked[i+1];
         end
         fill_in = CNT_W'(HOLD_DEPTH);
      end
   end

   // hold window state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= hold_in;
      end
   end

endmodule

/* design/spfl_queue.sv */
// Output word queue: loads a burst of up to five words, drains one a cycle while out_stall is low.
`timescale 1ns / 1ps

module spfl_queue
   import spfl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  burst_type burst,
   output logic      space,
   output logic      out_valid,
   input  logic      out_stall,
   output bin_type   out_word
);

   win_type          slot_ff, slot_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop;

   assign out_valid = (cnt_ff != '0);
   assign pop       = out_valid && !out_stall;
   assign out_word  = slot_ff[0];
   // room for a new burst once the queue is empty after this cycle
   assign space     = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && pop);

   // load a burst or advance the queue
   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         slot_in = burst.slot;
         cnt_in  = burst.count;
      end else if (pop) begin
         for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

/* verif/spectral_peak_frequency_lock_unit_test.sv */
// Self-checking testbench for the spectral peak frequency lock unit.
`timescale 1ns / 1ps

module spectral_peak_frequency_lock_unit_test;
   import spfl_pkg::*;

   localparam int IDLE_LIMIT   = 3000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_WAIT  = 8;
   localparam int RANDOM_BINS  = 140;

   // Window predictor plus queue of words the block still owes
   class freq_lock_scoreboard;
      bit                       lock_en = 1'b1;
      logic [AMP_W-1:0]         win_amp [WIN_DEPTH];
      logic signed [FREQ_W-1:0] win_freq [WIN_DEPTH];
      int                       fill = 0;
      bin_type                  owed_words[$];
      int                       errors = 0;
      int                       words_checked = 0;
      int                       frames_seen = 0;
      int                       peaks_locked = 0;

      function new();
         foreach (win_amp[k]) begin
            win_amp[k]  = '0;
            win_freq[k] = '0;
         end
      endfunction

      function int pending();
         return owed_words.size();
      endfunction

      // Slide the bin into the window, lock around a peak, queue what leaves
      function void note_bin(logic [AMP_W-1:0] amp, logic signed [FREQ_W-1:0] freq,
                             logic last);
         int slot;
         longint peak;
         longint diff;
         bin_type w;
         slot = (fill >= WIN_DEPTH) ? WIN_DEPTH - 1 : fill;
         win_amp[slot]  = amp;
         win_freq[slot] = freq;
         fill = slot + 1;
         if (fill == WIN_DEPTH && lock_en &&
             win_amp[2] > win_amp[0] && win_amp[2] > win_amp[1] &&
             win_amp[2] > win_amp[3] && win_amp[2] > win_amp[4]) begin
            peaks_locked++;
            peak = longint'(win_freq[2]);
            for (int k = 0; k < WIN_DEPTH; k++) begin
               diff = longint'(win_freq[k]) - peak;
               if (diff < 0) diff = -diff;
               if (diff * TOL_SCALE < peak) win_freq[k] = win_freq[2];
            end
         end
         if (last) begin
            for (int k = 0; k < fill; k++) begin
               w.amp  = win_amp[k];
               w.freq = win_freq[k];
               w.last = (k == fill - 1);
               owed_words.push_back(w);
            end
            fill = 0;
            frames_seen++;
         end else if (fill == WIN_DEPTH) begin
            w.amp  = win_amp[0];
            w.freq = win_freq[0];
            w.last = 1'b0;
            owed_words.push_back(w);
            for (int k = 0; k < HOLD_DEPTH; k++) begin
               win_amp[k]  = win_amp[k + 1];
               win_freq[k] = win_freq[k + 1];
            end
            fill = HOLD_DEPTH;
         end
      endfunction

      // Compare one emitted word against the oldest owed one
      function void check_word(logic [AMP_W-1:0] amp, logic signed [FREQ_W-1:0] freq,
                               logic fend);
         bin_type w;
         if (owed_words.size() == 0) begin
            $error("unexpected word: out_amplitude %h out_frequency %h frame_end %b",
                   amp, freq, fend);
            errors++;
            return;
         end
         w = owed_words.pop_front();
         words_checked++;
         if (w.amp !== amp) begin
            $error("out_amplitude: expected %h, got %h", w.amp, amp);
            errors++;
         end
         if (w.freq !== freq) begin
            $error("out_frequency: expected %0d, got %0d", w.freq, freq);
            errors++;
         end
         if (w.last !== fend) begin
            $error("frame_end: expected %b, got %b", w.last, fend);
            errors++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [AMP_W-1:0]         req_bin_amplitude;
   logic signed [FREQ_W-1:0] req_bin_frequency;
   logic                     req_last_bin;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [AMP_W-1:0]         rsp_out_amplitude;
   logic signed [FREQ_W-1:0] rsp_out_frequency;
   logic                     rsp_frame_end;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_W-1:0]    csr_paddr;
   logic [31:0]              csr_pwdata;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   freq_lock_scoreboard sb = new();
   int  burst_left = 0;
   int  bins_sent = 0;
   int  lock_writes = 0;
   bit  pressure_req;

   spectral_peak_frequency_lock_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_bin_amplitude (req_bin_amplitude),
      .req_bin_frequency (req_bin_frequency),
      .req_last_bin      (req_last_bin),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_amplitude (rsp_out_amplitude),
      .rsp_out_frequency (rsp_out_frequency),
      .rsp_frame_end     (rsp_frame_end),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offer one bin, opening a new burst after a random gap when the old one ends
   task automatic send_bin(input logic [AMP_W-1:0] amp, input logic signed [FREQ_W-1:0] freq,
                           input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_bin_amplitude <= amp;
      req_bin_frequency <= freq;
      req_last_bin      <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_bin(amp, freq, last);
      burst_left--;
      bins_sent++;
   endtask

   // One APB transfer: setup cycle, then access until pready
   task automatic csr_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_W'({CSR_IDX_LOCK_ENABLE, 2'b00});
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Drain the block, then write lock_enable and read it back
   task automatic set_lock(input bit enable);
      logic [31:0] rd;
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      csr_xfer(1'b1, {31'b0, enable}, rd);
      sb.lock_en = enable;
      csr_xfer(1'b0, 32'b0, rd);
      if (rd !== {31'b0, enable}) begin
         $error("lock_enable readback: expected %h, got %h", {31'b0, enable}, rd);
         sb.errors++;
      end
      lock_writes++;
   endtask

   // Result side: stall on a changing pattern, hold off long when asked
   initial begin
      int mode;
      int mode_left;
      int hold_left;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_req) begin
            pressure_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // Check every accepted output word
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            sb.check_word(rsp_out_amplitude, rsp_out_frequency, rsp_frame_end);
      end
   end

   // Abort when neither channel moves for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout after %0d idle cycles, %0d words still owed",
               idle_cycles, sb.pending());
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [31:0]              rd;
      int                       frame_len;
      int                       kind;
      int                       next_peak;
      int                       frame_no;
      int                       random_target;
      longint                   center_f;
      longint                   span;
      logic [AMP_W-1:0]         amp;
      logic signed [FREQ_W-1:0] freq;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_bin_amplitude = '0;
      req_bin_frequency = '0;
      req_last_bin      = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // lock_enable must come out of reset set
      csr_xfer(1'b0, 32'b0, rd);
      if (rd !== 32'd1) begin
         $error("lock_enable after reset: expected %h, got %h", 32'd1, rd);
         sb.errors++;
      end

      // Peak at bin 2 pulls the near neighbors onto its frequency
      send_bin(24'd1,  32'sd255000, 1'b0);
      send_bin(24'd2,  32'sd240000, 1'b0);
      send_bin(24'd50, 32'sd256000, 1'b0);
      send_bin(24'd3,  32'sd257000, 1'b0);
      send_bin(24'd4,  32'sd258500, 1'b0);
      send_bin(24'd0,  32'sd0,      1'b1);
      // Short frame with field extremes passes unchanged
      send_bin(24'hFFFFFF, 32'sh7FFFFFFF, 1'b0);
      send_bin(24'h000000, 32'sh80000000, 1'b0);
      send_bin(24'h800000, 32'shFFFFFFFF, 1'b1);
      // Single-bin frame
      send_bin(24'd123, -32'sd5, 1'b1);
      // Negative peak frequency never snaps
      send_bin(24'd1, -32'sd100, 1'b0);
      send_bin(24'd2, -32'sd101, 1'b0);
      send_bin(24'd9, -32'sd100, 1'b0);
      send_bin(24'd2, -32'sd100, 1'b0);
      send_bin(24'd1, -32'sd99,  1'b1);
      // Large edge bins are never centers; lock drops mid-frame before the peak
      send_bin(24'hFFFFFF, 32'sd100000, 1'b0);
      send_bin(24'd1,      32'sd100000, 1'b0);
      send_bin(24'd2,      32'sd100100, 1'b0);
      set_lock(1'b0);
      send_bin(24'd40,     32'sd100010, 1'b0);
      send_bin(24'd3,      32'sd100000, 1'b0);
      send_bin(24'hFFFFFE, 32'sd100020, 1'b1);
      set_lock(1'b1);

      // Random frames, mostly peaky spectra with clustered frequencies
      frame_no = 0;
      random_target = bins_sent + RANDOM_BINS;
      while (bins_sent < random_target) begin
         if (frame_no == 3) pressure_req = 1'b1;
         // keep offering bins while the long hold-off runs
         if (frame_no > 0 && frame_no != 3 && frame_no != 4 &&
             $urandom_range(0, 5) == 0)
            set_lock(1'($urandom_range(0, 1)));
         case ($urandom_range(0, 9))
            0, 1:    frame_len = $urandom_range(1, 4);
            9:       frame_len = $urandom_range(20, 32);
            default: frame_len = $urandom_range(5, 14);
         endcase
         kind = $urandom_range(0, 3);
         center_f = $urandom_range(256, 32'h3FFF_FFFF);
         case ($urandom_range(0, 9))
            0:       center_f = -center_f;
            1:       center_f = 0;
            default: ;
         endcase
         span = (center_f < 0 ? -center_f : center_f) / 50 + 1;
         next_peak = $urandom_range(2, 4);
         for (int j = 0; j < frame_len; j++) begin
            if (kind == 0) begin
               amp  = AMP_W'($urandom);
               freq = FREQ_W'($urandom);
            end else begin
               if (j == next_peak) begin
                  amp = (kind == 3) ? AMP_W'($urandom_range(2, 3))
                                    : AMP_W'($urandom_range(4096, 24'hFFFFFF));
                  next_peak += $urandom_range(3, 6);
               end else begin
                  amp = (kind == 3) ? AMP_W'($urandom_range(0, 2))
                                    : AMP_W'($urandom_range(0, 4095));
               end
               freq = FREQ_W'(center_f + longint'($urandom_range(0, 32'(2 * span))) - span);
            end
            send_bin(amp, freq, j == frame_len - 1);
         end
         frame_no++;
      end

      // Let everything owed come out, then give stray words a chance to show
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("Sent %0d bins in %0d frames, checked %0d words, %0d peaks locked",
               bins_sent, sb.frames_seen, sb.words_checked, sb.peaks_locked);
      $display("lock_enable written %0d times, with one long output hold-off", lock_writes);
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
